// File: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the scheduler block.
// Defining NO_ASSERTIONS turns every macro into an empty statement.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rstn, prop, msg)
`define ASSERT_NEVER(label, clk, rstn, cond, msg)
`endif
`endif

// File: rtl/core/rmts_pkg.sv
// Package of the rate-monotonic task scheduler: codes, widths and the
// command and status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps
package rmts_pkg;

    localparam int DEFAULT_MAX_TASKS = 16;
    localparam int DEFAULT_TIME_BITS = 32;

    localparam int FUNC_W      = 2;
    localparam int ID_W        = 22;
    localparam int PERIOD_W    = 16;
    localparam int SLICE_W     = 16;
    localparam int UTIL_W      = 11;
    localparam int BOUND_W     = 10;
    localparam int STATUS_W    = 2;
    localparam int DIVIDEND_W  = 26;
    localparam int DIV_CNT_W   = 5;
    localparam int SUM_W       = 27;
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 32;

    localparam logic [BOUND_W-1:0]    BOUND_RESET = 10'd639;
    localparam logic [DIVIDEND_W-1:0] UTIL_SCALE  = 26'd1000;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_REGISTER   = 2'd0,
        FUNC_YIELD      = 2'd1,
        FUNC_DEREGISTER = 2'd2,
        FUNC_TICK       = 2'd3
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_DONE      = 2'd0,
        STATUS_REFUSED   = 2'd1,
        STATUS_FULL      = 2'd2,
        STATUS_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        MODE_READY    = 2'd1,
        MODE_RUNNING  = 2'd2,
        MODE_SLEEPING = 2'd3
    } mode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FIND,
        ST_DIVW,
        ST_APPLY,
        ST_DSCAN,
        ST_DECIDE,
        ST_PREEMPT,
        ST_COMMIT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic find_step;
        logic apply;
        logic dscan_step;
        logic preempt;
        logic commit;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic scan_last;
        logic is_reg;
        logic div_done;
        logic do_preempt;
        logic want_commit;
        logic out_busy;
    } dp_stat_t;

endpackage

// File: rtl/core/rmts_div.sv
// Restoring divider, one quotient bit per cycle, for the utilization figure.
// Depends on rmts_pkg for the operand widths.
`timescale 1ns / 1ps
module rmts_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [rmts_pkg::DIVIDEND_W-1:0] dividend,
    input  logic [rmts_pkg::PERIOD_W-1:0]   divisor,
    output logic [rmts_pkg::DIVIDEND_W-1:0] quotient,
    output logic                           done
);
    import rmts_pkg::*;

    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [PERIOD_W:0]     rem_reg, rem_next;
    logic [PERIOD_W-1:0]   dvs_reg;
    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [PERIOD_W:0]     rem_sh;

    always_comb
    begin
        rem_sh    = {rem_reg[PERIOD_W-1:0], quo_reg[DIVIDEND_W-1]};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = DIV_CNT_W'(DIVIDEND_W);
            busy_next = 1'b1;
            done_next = 1'b0;
        end
        else if (busy_reg)
        begin
            if (rem_sh >= {1'b0, dvs_reg})
            begin
                rem_next = rem_sh - {1'b0, dvs_reg};
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh;
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
        begin
            dvs_reg <= divisor;
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

// File: rtl/core/rmts_datapath.sv
// Datapath of the scheduler: task table, time, runner, scan registers and result.
// Depends on rmts_pkg and instantiates rmts_div.
`timescale 1ns / 1ps
module rmts_datapath #(
    parameter int MAX_TASKS = rmts_pkg::DEFAULT_MAX_TASKS,
    parameter int TIME_BITS = rmts_pkg::DEFAULT_TIME_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  rmts_pkg::dp_cmd_t               cmd,
    output rmts_pkg::dp_stat_t              stat,
    input  logic [rmts_pkg::IN_TDATA_W-1:0] in_data,
    input  logic [rmts_pkg::FUNC_W-1:0]     in_user,
    input  logic                            cfg_valid,
    input  logic [rmts_pkg::BOUND_W-1:0]    cfg_data,
    input  logic                            out_ready,
    output logic                            out_valid,
    output logic [rmts_pkg::OUT_TDATA_W-1:0] out_data
);
    import rmts_pkg::*;

    localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

    logic [ID_W-1:0]      entry_id_reg      [MAX_TASKS];
    logic [PERIOD_W-1:0]  entry_period_reg  [MAX_TASKS];
    logic [UTIL_W-1:0]    entry_util_reg    [MAX_TASKS];
    mode_t                entry_mode_reg    [MAX_TASKS];
    logic [TIME_BITS-1:0] entry_release_reg [MAX_TASKS];
    logic [TIME_BITS-1:0] entry_wake_reg    [MAX_TASKS];
    logic [MAX_TASKS-1:0] entry_valid_reg;
    logic [MAX_TASKS-1:0] entry_armed_reg;

    logic [BOUND_W-1:0]   bound_reg;
    logic [TIME_BITS-1:0] time_now_reg;
    logic [IDX_W-1:0]     idx_reg;
    func_t                func_reg;
    logic [ID_W-1:0]      tid_reg;
    logic [PERIOD_W-1:0]  period_in_reg;

    logic                 cur_valid_reg, was_valid_reg;
    logic [IDX_W-1:0]     cur_slot_reg, was_slot_reg;
    logic [ID_W-1:0]      cur_id_reg;
    logic [PERIOD_W-1:0]  cur_period_reg;

    logic                 found_reg, free_found_reg;
    logic [IDX_W-1:0]     found_slot_reg, free_slot_reg;
    logic [TIME_BITS-1:0] found_release_reg;
    logic [PERIOD_W-1:0]  found_period_reg;
    logic [SUM_W-1:0]     sum_reg;

    logic                 best_found_reg;
    logic [IDX_W-1:0]     best_slot_reg;
    logic [PERIOD_W-1:0]  best_period_reg;
    logic [ID_W-1:0]      best_id_reg;

    status_t              status_reg;
    logic                 out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;

    logic [DIVIDEND_W-1:0] div_quo;
    logic                  div_done;
    logic [DIVIDEND_W-1:0] dividend;

    logic [ID_W-1:0]      rd_id;
    logic [PERIOD_W-1:0]  rd_period;
    mode_t                rd_mode;
    logic                 rd_valid;
    logic [TIME_BITS-1:0] wake_diff, yield_diff;
    logic                 tick_wake, scan_match, cand, better;
    logic                 yield_late, reg_refused, self_hit;
    logic                 switched;

    assign dividend = DIVIDEND_W'(in_data[ID_W+PERIOD_W +: SLICE_W]) * UTIL_SCALE;

    rmts_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.load),
        .dividend (dividend),
        .divisor  (in_data[ID_W +: PERIOD_W]),
        .quotient (div_quo),
        .done     (div_done)
    );

    always_comb
    begin
        rd_id      = entry_id_reg[idx_reg];
        rd_period  = entry_period_reg[idx_reg];
        rd_mode    = entry_mode_reg[idx_reg];
        rd_valid   = entry_valid_reg[idx_reg];
        wake_diff  = time_now_reg - entry_wake_reg[idx_reg];
        tick_wake  = (func_reg == FUNC_TICK) && rd_valid && entry_armed_reg[idx_reg]
                     && !wake_diff[TIME_BITS-1];
        scan_match = rd_valid && (rd_id == tid_reg);
        cand       = rd_valid && (rd_mode == MODE_READY);
        better     = !best_found_reg || (rd_period < best_period_reg)
                     || ((rd_period == best_period_reg) && (rd_id < best_id_reg));
        yield_diff = found_release_reg - time_now_reg;
        yield_late = (yield_diff == '0) || yield_diff[TIME_BITS-1];
        reg_refused = (period_in_reg == '0) || found_reg
                      || ((SUM_W'(div_quo) + sum_reg) > SUM_W'(bound_reg));
        self_hit   = cur_valid_reg && (cur_slot_reg == found_slot_reg);
        switched   = (was_valid_reg != cur_valid_reg)
                     || (cur_valid_reg && (was_slot_reg != cur_slot_reg));
    end

    assign stat.scan_last   = (idx_reg == IDX_W'(MAX_TASKS - 1));
    assign stat.is_reg      = (func_reg == FUNC_REGISTER);
    assign stat.div_done    = div_done;
    assign stat.do_preempt  = best_found_reg && cur_valid_reg && (best_period_reg < cur_period_reg);
    assign stat.want_commit = best_found_reg && (!cur_valid_reg || (best_period_reg < cur_period_reg));
    assign stat.out_busy    = out_valid_reg && !out_ready;

    // Control state and valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bound_reg       <= BOUND_RESET;
            time_now_reg    <= '0;
            idx_reg         <= '0;
            entry_valid_reg <= '0;
            entry_armed_reg <= '0;
            cur_valid_reg   <= 1'b0;
            cur_slot_reg    <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                bound_reg <= cfg_data;
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.load)
            begin
                if (func_t'(in_user) == FUNC_TICK)
                begin
                    time_now_reg <= time_now_reg + 1'b1;
                end
            end
            if (cmd.find_step || cmd.dscan_step)
            begin
                idx_reg <= stat.scan_last ? '0 : idx_reg + 1'b1;
            end
            if (cmd.find_step && tick_wake)
            begin
                entry_armed_reg[idx_reg] <= 1'b0;
            end
            if (cmd.apply)
            begin
                case (func_reg)
                    FUNC_REGISTER:
                    begin
                        if (!reg_refused && free_found_reg)
                        begin
                            entry_valid_reg[free_slot_reg] <= 1'b1;
                            entry_armed_reg[free_slot_reg] <= 1'b0;
                        end
                    end
                    FUNC_YIELD:
                    begin
                        if (found_reg)
                        begin
                            if (self_hit)
                            begin
                                cur_valid_reg <= 1'b0;
                            end
                            entry_armed_reg[found_slot_reg] <= !yield_late;
                        end
                    end
                    FUNC_DEREGISTER:
                    begin
                        if (found_reg)
                        begin
                            if (self_hit)
                            begin
                                cur_valid_reg <= 1'b0;
                            end
                            entry_valid_reg[found_slot_reg] <= 1'b0;
                            entry_armed_reg[found_slot_reg] <= 1'b0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.dscan_step && cur_valid_reg && (idx_reg == cur_slot_reg)
                && (!rd_valid || (rd_mode != MODE_RUNNING)))
            begin
                cur_valid_reg <= 1'b0;
            end
            if (cmd.commit)
            begin
                cur_valid_reg <= 1'b1;
                cur_slot_reg  <= best_slot_reg;
            end
        end
    end

    // Table payload and scan registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg       <= func_t'(in_user);
            tid_reg        <= in_data[ID_W-1:0];
            period_in_reg  <= in_data[ID_W +: PERIOD_W];
            was_valid_reg  <= cur_valid_reg;
            was_slot_reg   <= cur_slot_reg;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            sum_reg        <= '0;
        end
        if (cmd.find_step)
        begin
            if (scan_match)
            begin
                found_reg         <= 1'b1;
                found_slot_reg    <= idx_reg;
                found_release_reg <= entry_release_reg[idx_reg];
                found_period_reg  <= rd_period;
            end
            if (rd_valid)
            begin
                sum_reg <= sum_reg + SUM_W'(entry_util_reg[idx_reg]);
            end
            else if (!free_found_reg)
            begin
                free_found_reg <= 1'b1;
                free_slot_reg  <= idx_reg;
            end
            if (tick_wake)
            begin
                entry_mode_reg[idx_reg] <= MODE_READY;
            end
        end
        if (cmd.apply)
        begin
            best_found_reg <= 1'b0;
            status_reg     <= STATUS_DONE;
            case (func_reg)
                FUNC_REGISTER:
                begin
                    if (reg_refused)
                    begin
                        status_reg <= STATUS_REFUSED;
                    end
                    else if (!free_found_reg)
                    begin
                        status_reg <= STATUS_FULL;
                    end
                    else
                    begin
                        entry_id_reg[free_slot_reg]      <= tid_reg;
                        entry_period_reg[free_slot_reg]  <= period_in_reg;
                        entry_util_reg[free_slot_reg]    <= div_quo[UTIL_W-1:0];
                        entry_mode_reg[free_slot_reg]    <= MODE_SLEEPING;
                        entry_release_reg[free_slot_reg] <= time_now_reg
                                                            + TIME_BITS'(period_in_reg);
                    end
                end
                FUNC_YIELD:
                begin
                    if (!found_reg)
                    begin
                        status_reg <= STATUS_NOT_FOUND;
                    end
                    else
                    begin
                        entry_mode_reg[found_slot_reg] <= yield_late ? MODE_READY
                                                                     : MODE_SLEEPING;
                        if (!yield_late)
                        begin
                            entry_wake_reg[found_slot_reg] <= found_release_reg;
                        end
                        entry_release_reg[found_slot_reg] <= found_release_reg
                                                             + TIME_BITS'(found_period_reg);
                    end
                end
                FUNC_DEREGISTER:
                begin
                    if (!found_reg)
                    begin
                        status_reg <= STATUS_NOT_FOUND;
                    end
                end
                default:
                begin
                end
            endcase
        end
        if (cmd.dscan_step && cand && better)
        begin
            best_found_reg  <= 1'b1;
            best_slot_reg   <= idx_reg;
            best_period_reg <= rd_period;
            best_id_reg     <= rd_id;
        end
        if (cmd.preempt)
        begin
            entry_mode_reg[cur_slot_reg] <= MODE_READY;
        end
        if (cmd.commit)
        begin
            entry_mode_reg[best_slot_reg] <= MODE_RUNNING;
            cur_id_reg     <= best_id_reg;
            cur_period_reg <= best_period_reg;
        end
        if (cmd.finish)
        begin
            out_data_reg <= {6'd0, switched,
                             cur_valid_reg ? cur_id_reg : {ID_W{1'b0}},
                             cur_valid_reg, status_reg};
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// File: rtl/core/rmts_ctrl.sv
// Controller of the scheduler: sequences lookup, update, dispatch and result.
// Depends on rmts_pkg.
`timescale 1ns / 1ps
module rmts_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  rmts_pkg::dp_stat_t stat,
    output rmts_pkg::dp_cmd_t  cmd
);
    import rmts_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_FIND;
                end
            end
            ST_FIND:
            begin
                cmd.find_step = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = stat.is_reg ? ST_DIVW : ST_APPLY;
                end
            end
            ST_DIVW:
            begin
                if (stat.div_done)
                begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                cmd.apply  = 1'b1;
                state_next = ST_DSCAN;
            end
            ST_DSCAN:
            begin
                cmd.dscan_step = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (stat.do_preempt)
                begin
                    state_next = ST_PREEMPT;
                end
                else if (stat.want_commit)
                begin
                    state_next = ST_COMMIT;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_PREEMPT:
            begin
                cmd.preempt = 1'b1;
                state_next  = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!stat.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/core/rate_monotonic_task_scheduler.sv
// Rate-monotonic task scheduler with utilization admission.
// Requests enter on s_axis (func in tuser) and one result per request leaves on
// m_axis. The single configuration register util_bound is written on cfg.
// Every request walks the task table twice, once to look up the named task and
// once to pick the ready task with the shortest period, one entry per cycle.
// After the first walk a registration also waits for the utilization divider when
// that is longer than the walk; the table is then updated and the second walk
// runs, with a preempt step when the runner is preempted and a commit step when
// a task is dispatched, before the result is registered.
// One request is in work at a time; s_axis_tready is high while the block is
// free, also while a finished result still waits in the output register.
// If m_axis is stalled, a second finished result waits until the first leaves.
// Reset clears the table valid bits, time and the runner, and sets util_bound
// to 639; cfg writes are always taken.
// Depends on rmts_pkg, rmts_ctrl, rmts_datapath and rmts_div.
`timescale 1ns / 1ps
module rate_monotonic_task_scheduler #(
    parameter int MAX_TASKS = rmts_pkg::DEFAULT_MAX_TASKS,
    parameter int TIME_BITS = rmts_pkg::DEFAULT_TIME_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // Fields from bit 0: task_id[21:0], period_ms[37:22], slice_ms[53:38], zero fill.
    input  logic [rmts_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // Fields from bit 0: func[1:0].
    input  logic [rmts_pkg::FUNC_W-1:0]      s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // Fields from bit 0: status[1:0], running_valid[2], running_id[24:3],
    // switched[25], zero fill.
    output logic [rmts_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [rmts_pkg::BOUND_W-1:0]     cfg_data
);
    import rmts_pkg::*;

    `include "assert_macros.svh"

    dp_cmd_t  cmd;
    dp_stat_t stat;

    assign cfg_ready = 1'b1;

    rmts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rmts_datapath #(
        .MAX_TASKS (MAX_TASKS),
        .TIME_BITS (TIME_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_data   (s_axis_tdata),
        .in_user   (s_axis_tuser),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_data  (m_axis_tdata)
    );

    `ASSERT_CLK(a_busy_after_accept, clk, rst_n, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready, "request accepted while busy")
    `ASSERT_NEVER(a_no_overwrite, clk, rst_n, cmd.finish && m_axis_tvalid && !m_axis_tready, "result overwrote a waiting result")
    `ASSERT_CLK(a_idle_id_zero, clk, rst_n, (m_axis_tvalid && !m_axis_tdata[2]) |-> (m_axis_tdata[24:3] == 22'd0), "running_id set without runner")

endmodule
